// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros
// Assertion helpers for the top RTL file of the reciprocal square root block.
// Each use sits on a line of its own at the end of a module that has i_clk and i_rst_n.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define FISR_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define FISR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/fisr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fisr_pkg
// Shared constants, types and helper functions of the reciprocal square root
// pipeline.
// ----------------------------------------------------------------------------
package fisr_pkg;

    localparam logic [31:0] MAGIC_S      = 32'h5f3759df;
    localparam logic [63:0] MAGIC_D      = 64'h5fe6ec85e7de30da;
    localparam logic [31:0] QNAN_S       = 32'h7fc00000;
    localparam logic [63:0] QNAN_D       = 64'h7ff8000000000000;
    localparam logic [31:0] HALF_S       = 32'h3f000000;
    localparam logic [63:0] HALF_D       = 64'h3fe0000000000000;
    localparam logic [31:0] THREE_HALF_S = 32'h3fc00000;
    localparam logic [63:0] THREE_HALF_D = 64'h3ff8000000000000;

    localparam int SIG_W = 106;

    typedef enum logic [1:0] {
        SP_NONE,
        SP_ZERO,
        SP_INF,
        SP_NAN
    } t_spec;

    // Data that rides alongside an operation through a unit.
    typedef struct packed {
        logic        dbl;
        logic [63:0] h;
        logic [63:0] y;
    } t_side;

    // Unpacked operand: subnormals carry exponent 1 and no hidden bit,
    // single mantissas are left aligned into the 53-bit field.
    typedef struct packed {
        logic        sgn;
        logic [11:0] ex;
        logic [52:0] man;
        logic        zero;
        logic        inf;
        logic        nan;
    } t_unp;

    // Control of a value on its way to normalising and rounding.
    typedef struct packed {
        logic               dbl;
        logic               sgn;
        t_spec              spec;
        logic signed [13:0] ex;
    } t_nctl;

    function automatic t_unp unpack(input logic dbl, input logic [63:0] v);
        t_unp        u;
        logic [10:0] ef;
        logic [51:0] fr;
        logic        all1;
        if (dbl) begin
            u.sgn = v[63];
            ef    = v[62:52];
            fr    = v[51:0];
            all1  = &v[62:52];
        end else begin
            u.sgn = v[31];
            ef    = {3'b0, v[30:23]};
            fr    = {v[22:0], 29'b0};
            all1  = &v[30:23];
        end
        u.ex   = (ef == 11'd0) ? 12'd1 : {1'b0, ef};
        u.man  = {ef != 11'd0, fr};
        u.zero = (ef == 11'd0) && (fr == 52'd0);
        u.inf  = all1 && (fr == 52'd0);
        u.nan  = all1 && (fr != 52'd0);
        return u;
    endfunction

    // Leading zero count of a significand.
    function automatic logic [6:0] lzc(input logic [SIG_W-1:0] v);
        logic [6:0] n;
        logic       found;
        n     = 7'd0;
        found = 1'b0;
        for (int i = SIG_W - 1; i >= 0; i--) begin
            if (!found) begin
                if (v[i]) begin
                    found = 1'b1;
                end else begin
                    n = n + 7'd1;
                end
            end
        end
        return n;
    endfunction

endpackage

// ===== rtl/fisr_nrm.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fisr_nrm
// Four-stage normalise, denormalise, round-to-nearest-even and pack back end.
// ----------------------------------------------------------------------------
module fisr_nrm (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_valid,
    input  fisr_pkg::t_nctl               i_ctl,
    input  logic [fisr_pkg::SIG_W-1:0]    i_sig,
    input  fisr_pkg::t_side               i_side,
    output logic                          o_valid,
    output logic [63:0]                   o_res,
    output fisr_pkg::t_side               o_side
);

    // Stage A: leading zero count
    logic                       r_a_v;
    fisr_pkg::t_nctl            r_a_ctl, n_a_ctl;
    logic [fisr_pkg::SIG_W-1:0] r_a_sig;
    logic [6:0]                 r_a_lz;
    fisr_pkg::t_side            r_a_side;
    // Stage B: normalised
    logic                       r_b_v;
    fisr_pkg::t_nctl            r_b_ctl, n_b_ctl;
    logic [fisr_pkg::SIG_W-1:0] r_b_sig, n_b_sig;
    fisr_pkg::t_side            r_b_side;
    // Stage C: denormalised where needed
    logic                       r_c_v;
    fisr_pkg::t_nctl            r_c_ctl, n_c_ctl;
    logic [fisr_pkg::SIG_W-1:0] r_c_sig, n_c_sig;
    fisr_pkg::t_side            r_c_side;
    logic [13:0]                n_sh;
    // Stage D: rounded and packed
    logic                       r_d_v;
    logic [63:0]                r_d_res, n_d_res;
    fisr_pkg::t_side            r_d_side;

    always_comb begin
        n_a_ctl = i_ctl;
        if (i_ctl.spec == fisr_pkg::SP_NONE && i_sig == '0) begin
            // exact cancellation gives +0 under round to nearest
            n_a_ctl.spec = fisr_pkg::SP_ZERO;
            n_a_ctl.sgn  = 1'b0;
        end
    end

    always_comb begin
        n_b_sig    = r_a_sig << r_a_lz;
        n_b_ctl    = r_a_ctl;
        n_b_ctl.ex = r_a_ctl.ex - $signed({7'b0, r_a_lz});
    end

    always_comb begin
        n_c_sig = r_b_sig;
        n_c_ctl = r_b_ctl;
        n_sh    = 14'(14'sd1 - r_b_ctl.ex);
        if (r_b_ctl.ex < 14'sd1) begin
            // push below the smallest normal exponent, fold lost bits into sticky
            if (n_sh > 14'd106) begin
                n_c_sig = {105'b0, |r_b_sig};
            end else begin
                n_c_sig = (r_b_sig >> n_sh[6:0])
                        | {105'b0, |(r_b_sig & ~({fisr_pkg::SIG_W{1'b1}} << n_sh[6:0]))};
            end
            n_c_ctl.ex = 14'sd1;
        end
    end

    always_comb begin
        logic [53:0]        kept;
        logic [53:0]        rnd;
        logic               g;
        logic               st;
        logic               hid;
        logic               ovf;
        logic signed [13:0] ex;
        fisr_pkg::t_spec    sp;
        if (r_c_ctl.dbl) begin
            kept = {1'b0, r_c_sig[105:53]};
            g    = r_c_sig[52];
            st   = |r_c_sig[51:0];
        end else begin
            kept = {30'b0, r_c_sig[105:82]};
            g    = r_c_sig[81];
            st   = |r_c_sig[80:0];
        end
        rnd = kept + {53'b0, g & (st | kept[0])};
        ex  = r_c_ctl.ex;
        if (r_c_ctl.dbl ? rnd[53] : rnd[24]) begin
            rnd = rnd >> 1;
            ex  = ex + 14'sd1;
        end
        hid = r_c_ctl.dbl ? rnd[52] : rnd[23];
        ovf = ex >= (r_c_ctl.dbl ? 14'sd2047 : 14'sd255);
        sp  = r_c_ctl.spec;
        if (sp == fisr_pkg::SP_NONE && ovf) begin
            sp = fisr_pkg::SP_INF;
        end
        if (r_c_ctl.dbl) begin
            unique case (sp)
                fisr_pkg::SP_NONE: n_d_res = {r_c_ctl.sgn, hid ? ex[10:0] : 11'd0, rnd[51:0]};
                fisr_pkg::SP_ZERO: n_d_res = {r_c_ctl.sgn, 63'b0};
                fisr_pkg::SP_INF:  n_d_res = {r_c_ctl.sgn, 11'h7ff, 52'b0};
                default:           n_d_res = fisr_pkg::QNAN_D;
            endcase
        end else begin
            unique case (sp)
                fisr_pkg::SP_NONE:
                    n_d_res = {32'b0, r_c_ctl.sgn, hid ? ex[7:0] : 8'd0, rnd[22:0]};
                fisr_pkg::SP_ZERO: n_d_res = {32'b0, r_c_ctl.sgn, 31'b0};
                fisr_pkg::SP_INF:  n_d_res = {32'b0, r_c_ctl.sgn, 8'hff, 23'b0};
                default:           n_d_res = {32'b0, fisr_pkg::QNAN_S};
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
            r_b_v <= 1'b0;
            r_c_v <= 1'b0;
            r_d_v <= 1'b0;
        end else if (i_en) begin
            r_a_v <= i_valid;
            r_b_v <= r_a_v;
            r_c_v <= r_b_v;
            r_d_v <= r_c_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_ctl  <= n_a_ctl;
            r_a_sig  <= i_sig;
            r_a_lz   <= fisr_pkg::lzc(i_sig);
            r_a_side <= i_side;
            r_b_ctl  <= n_b_ctl;
            r_b_sig  <= n_b_sig;
            r_b_side <= r_a_side;
            r_c_ctl  <= n_c_ctl;
            r_c_sig  <= n_c_sig;
            r_c_side <= r_b_side;
            r_d_res  <= n_d_res;
            r_d_side <= r_c_side;
        end
    end

    assign o_valid = r_d_v;
    assign o_res   = r_d_res;
    assign o_side  = r_d_side;

endmodule

// ===== rtl/fisr_fmul.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fisr_fmul
// Pipelined IEEE multiply at single or double precision: partial products,
// product sum, then the shared normalise and round back end.
// ----------------------------------------------------------------------------
module fisr_fmul (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_valid,
    input  logic [63:0]     i_a,
    input  logic [63:0]     i_b,
    input  fisr_pkg::t_side i_side,
    output logic            o_valid,
    output logic [63:0]     o_res,
    output fisr_pkg::t_side o_side
);

    fisr_pkg::t_unp             ua, ub;
    fisr_pkg::t_nctl            n_ctl;
    logic signed [13:0]         bias;

    logic                       r1_v;
    fisr_pkg::t_nctl            r1_ctl;
    logic [51:0]                r1_hh;
    logic [52:0]                r1_hl, r1_lh;
    logic [53:0]                r1_ll;
    fisr_pkg::t_side            r1_side;

    logic                       r2_v;
    fisr_pkg::t_nctl            r2_ctl;
    logic [fisr_pkg::SIG_W-1:0] r2_sig, n2_sig;
    fisr_pkg::t_side            r2_side;
    logic [53:0]                n2_cross;

    always_comb begin
        ua        = fisr_pkg::unpack(i_side.dbl, i_a);
        ub        = fisr_pkg::unpack(i_side.dbl, i_b);
        bias      = i_side.dbl ? 14'sd1023 : 14'sd127;
        n_ctl.dbl = i_side.dbl;
        n_ctl.sgn = ua.sgn ^ ub.sgn;
        n_ctl.ex  = $signed({2'b0, ua.ex}) + $signed({2'b0, ub.ex}) - bias + 14'sd1;
        if (ua.nan || ub.nan || (ua.inf && ub.zero) || (ua.zero && ub.inf)) begin
            n_ctl.spec = fisr_pkg::SP_NAN;
        end else if (ua.inf || ub.inf) begin
            n_ctl.spec = fisr_pkg::SP_INF;
        end else if (ua.zero || ub.zero) begin
            n_ctl.spec = fisr_pkg::SP_ZERO;
        end else begin
            n_ctl.spec = fisr_pkg::SP_NONE;
        end
    end

    // sum the four partial products into the full 106-bit product
    always_comb begin
        n2_cross = {1'b0, r1_hl} + {1'b0, r1_lh};
        n2_sig   = {r1_hh, 54'b0} + {25'b0, n2_cross, 27'b0} + {52'b0, r1_ll};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
        end else if (i_en) begin
            r1_v <= i_valid;
            r2_v <= r1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_ctl  <= n_ctl;
            r1_hh   <= ua.man[52:27] * ub.man[52:27];
            r1_hl   <= ua.man[52:27] * ub.man[26:0];
            r1_lh   <= ua.man[26:0]  * ub.man[52:27];
            r1_ll   <= ua.man[26:0]  * ub.man[26:0];
            r1_side <= i_side;
            r2_ctl  <= r1_ctl;
            r2_sig  <= n2_sig;
            r2_side <= r1_side;
        end
    end

    fisr_nrm u_nrm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (i_en),
        .i_valid (r2_v),
        .i_ctl   (r2_ctl),
        .i_sig   (r2_sig),
        .i_side  (r2_side),
        .o_valid (o_valid),
        .o_res   (o_res),
        .o_side  (o_side)
    );

endmodule

// ===== rtl/fisr_fsub.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fisr_fsub
// Pipelined IEEE subtract 1.5 - b at single or double precision: compare,
// align, add, then the shared normalise and round back end.
// ----------------------------------------------------------------------------
module fisr_fsub (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_valid,
    input  logic [63:0]     i_b,
    input  fisr_pkg::t_side i_side,
    output logic            o_valid,
    output logic [63:0]     o_res,
    output fisr_pkg::t_side o_side
);

    fisr_pkg::t_unp             ua, ub;
    logic                       n_sb, n_abig;

    logic                       r1_v;
    fisr_pkg::t_spec            r1_spec, n1_spec;
    logic                       r1_sgn, r1_sub;
    logic [11:0]                r1_el, r1_d;
    logic [52:0]                r1_ml, r1_ms;
    fisr_pkg::t_side            r1_side;

    logic                       r2_v;
    fisr_pkg::t_spec            r2_spec;
    logic                       r2_sgn, r2_sub;
    logic [11:0]                r2_el;
    logic [fisr_pkg::SIG_W-1:0] r2_lw, r2_sw, n2_sw, n2_sfull;
    fisr_pkg::t_side            r2_side;

    logic                       r3_v;
    fisr_pkg::t_nctl            r3_ctl;
    logic [fisr_pkg::SIG_W-1:0] r3_sig;
    fisr_pkg::t_side            r3_side;

    always_comb begin
        ub     = fisr_pkg::unpack(i_side.dbl, i_b);
        ua     = fisr_pkg::unpack(i_side.dbl, i_side.dbl ? fisr_pkg::THREE_HALF_D
                                                         : {32'b0, fisr_pkg::THREE_HALF_S});
        n_sb   = ~ub.sgn;
        n_abig = {ua.ex, ua.man} >= {ub.ex, ub.man};
        if (ub.nan) begin
            n1_spec = fisr_pkg::SP_NAN;
        end else if (ub.inf) begin
            n1_spec = fisr_pkg::SP_INF;
        end else begin
            n1_spec = fisr_pkg::SP_NONE;
        end
    end

    // align the smaller operand, lost bits kept as sticky
    always_comb begin
        n2_sfull = {1'b0, r1_ms, 52'b0};
        if (r1_d >= 12'd106) begin
            n2_sw = {105'b0, |r1_ms};
        end else begin
            n2_sw = (n2_sfull >> r1_d[6:0])
                  | {105'b0, |(n2_sfull & ~({fisr_pkg::SIG_W{1'b1}} << r1_d[6:0]))};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
        end else if (i_en) begin
            r1_v <= i_valid;
            r2_v <= r1_v;
            r3_v <= r2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_spec    <= n1_spec;
            r1_sgn     <= (ub.inf || !n_abig) ? n_sb : ua.sgn;
            r1_sub     <= ua.sgn ^ n_sb;
            r1_el      <= n_abig ? ua.ex  : ub.ex;
            r1_ml      <= n_abig ? ua.man : ub.man;
            r1_ms      <= n_abig ? ub.man : ua.man;
            r1_d       <= n_abig ? (ua.ex - ub.ex) : (ub.ex - ua.ex);
            r1_side    <= i_side;
            r2_spec    <= r1_spec;
            r2_sgn     <= r1_sgn;
            r2_sub     <= r1_sub;
            r2_el      <= r1_el;
            r2_lw      <= {1'b0, r1_ml, 52'b0};
            r2_sw      <= n2_sw;
            r2_side    <= r1_side;
            r3_ctl.dbl  <= r2_side.dbl;
            r3_ctl.sgn  <= r2_sgn;
            r3_ctl.spec <= r2_spec;
            r3_ctl.ex   <= $signed({2'b0, r2_el}) + 14'sd1;
            r3_sig      <= r2_sub ? (r2_lw - r2_sw) : (r2_lw + r2_sw);
            r3_side     <= r2_side;
        end
    end

    fisr_nrm u_nrm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (i_en),
        .i_valid (r3_v),
        .i_ctl   (r3_ctl),
        .i_sig   (r3_sig),
        .i_side  (r3_side),
        .o_valid (o_valid),
        .o_res   (o_res),
        .o_side  (o_side)
    );

endmodule

// ===== rtl/fisr_newton.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fisr_newton
// One Newton step y * (1.5 - (h * y) * y) as a chain of pipelined units.
// ----------------------------------------------------------------------------
module fisr_newton (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_hold_single,
    input  logic            i_valid,
    input  fisr_pkg::t_side i_side,
    output logic            o_valid,
    output fisr_pkg::t_side o_side
);

    logic            m1_v, m2_v, s_v, m3_v;
    logic [63:0]     m1_res, m2_res, s_res, m3_res;
    fisr_pkg::t_side m1_side, m2_side, s_side, m3_side;

    fisr_fmul u_mul_hy (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_en (i_en),
        .i_valid (i_valid), .i_a (i_side.h), .i_b (i_side.y), .i_side (i_side),
        .o_valid (m1_v), .o_res (m1_res), .o_side (m1_side)
    );

    fisr_fmul u_mul_ty (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_en (i_en),
        .i_valid (m1_v), .i_a (m1_res), .i_b (m1_side.y), .i_side (m1_side),
        .o_valid (m2_v), .o_res (m2_res), .o_side (m2_side)
    );

    fisr_fsub u_sub (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_en (i_en),
        .i_valid (m2_v), .i_b (m2_res), .i_side (m2_side),
        .o_valid (s_v), .o_res (s_res), .o_side (s_side)
    );

    fisr_fmul u_mul_yt (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_en (i_en),
        .i_valid (s_v), .i_a (s_side.y), .i_b (s_res), .i_side (s_side),
        .o_valid (m3_v), .o_res (m3_res), .o_side (m3_side)
    );

    // hold the incoming estimate for single items where this step is not used
    always_comb begin
        o_side     = m3_side;
        o_side.y   = (i_hold_single && !m3_side.dbl) ? m3_side.y : m3_res;
    end

    assign o_valid = m3_v;

endmodule

// ===== rtl/fast_inverse_square_root.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fast_inverse_square_root
// Approximate 1/sqrt(x) of an IEEE single or double operand: bit-trick first
// guess followed by one (single) or two (double) Newton steps.
// ----------------------------------------------------------------------------
// One result per transfer in, in order, with a throughput of one item per clock
// while the receiver keeps taking results. The depth is set by the chain of nine
// floating-point units (one halving multiply, then two Newton steps of three
// multiplies and one subtract), each a multiply or subtract pipeline,
// plus the input register. Single items pass the second Newton step
// with their estimate held. Every operation rounds to nearest even at the
// selected precision with full subnormal, infinity and NaN handling; any NaN
// result is delivered as the canonical quiet NaN. Single results sit in the
// low 32 bits with the upper half zero. The whole pipeline advances as one:
// while a finished result waits on i_ready, every stage holds.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module fast_inverse_square_root (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_action,
    input  logic [63:0] i_operand_bits,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [63:0] o_result_bits
);

    logic            adv;
    logic            r_v0;
    fisr_pkg::t_side r_side0, n_side0;
    logic            h_v, n1_v, n2_v;
    logic [63:0]     h_res;
    fisr_pkg::t_side h_side, h_side_fix, n1_side, n2_side;
    logic            out_single;
    logic            out_dbl_nan;

    // advance everything unless a result is waiting to be taken
    assign adv     = !o_valid || i_ready;
    assign o_ready = adv;

    // first guess from the bit pattern; carry x in the h slot until halved
    always_comb begin
        n_side0.dbl = i_action;
        if (i_action) begin
            n_side0.h = i_operand_bits;
            n_side0.y = fisr_pkg::MAGIC_D - {1'b0, i_operand_bits[63:1]};
        end else begin
            n_side0.h = {32'b0, i_operand_bits[31:0]};
            n_side0.y = {32'b0, fisr_pkg::MAGIC_S
                                - {i_operand_bits[31], i_operand_bits[31:1]}};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
        end else if (adv) begin
            r_v0 <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && i_valid) begin
            r_side0 <= n_side0;
        end
    end

    // h = 0.5 * x
    fisr_fmul u_half (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_valid (r_v0),
        .i_a     (r_side0.h),
        .i_b     (r_side0.dbl ? fisr_pkg::HALF_D : {32'b0, fisr_pkg::HALF_S}),
        .i_side  (r_side0),
        .o_valid (h_v),
        .o_res   (h_res),
        .o_side  (h_side)
    );

    always_comb begin
        h_side_fix   = h_side;
        h_side_fix.h = h_res;
    end

    fisr_newton u_step1 (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_en          (adv),
        .i_hold_single (1'b0),
        .i_valid       (h_v),
        .i_side        (h_side_fix),
        .o_valid       (n1_v),
        .o_side        (n1_side)
    );

    // second step refines double items only
    fisr_newton u_step2 (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_en          (adv),
        .i_hold_single (1'b1),
        .i_valid       (n1_v),
        .i_side        (n1_side),
        .o_valid       (n2_v),
        .o_side        (n2_side)
    );

    assign o_valid       = n2_v;
    assign o_result_bits = n2_side.y;

    assign out_single  = o_valid && !n2_side.dbl;
    assign out_dbl_nan = o_valid && n2_side.dbl && (&o_result_bits[62:52])
                         && (o_result_bits[51:0] != 52'd0);

    `FISR_ASSERT_NOW(a_single_upper_zero, out_single, o_result_bits[63:32] == 32'd0, "upper bits set")
    `FISR_ASSERT_NOW(a_nan_canonical, out_dbl_nan, o_result_bits == fisr_pkg::QNAN_D, "NaN not canonical")
    `FISR_ASSERT_NOW(a_entry_from_transfer, $rose(r_v0), $past(i_valid && o_ready), "no transfer")

endmodule

// ===== verif/fast_inverse_square_root_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fast_inverse_square_root_test
// Self-checking bench for the reciprocal square root pipeline. A bit-exact
// software float model predicts every result. Operands cover both precisions,
// signed zeros, infinities, NaNs, subnormals and random patterns. Both sides
// of the block idle at random, with one long receiver hold-off and pauses to
// drain the block.
// ----------------------------------------------------------------------------
module fast_inverse_square_root_test;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int RANDOM_ITEMS = 1300;
    localparam int IDLE_PCT     = 37;

    // Operand classes, as seen by the software float model
    localparam int CL_ZERO   = 0;
    localparam int CL_FINITE = 1;
    localparam int CL_INF    = 2;
    localparam int CL_NAN    = 3;

    typedef struct {
        bit          drain;     // hold the sender until the block is empty
        logic        action;
        logic [63:0] operand;
    } t_job;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic        i_action;
    logic [63:0] i_operand_bits;
    logic        o_valid;
    logic        i_ready;
    logic [63:0] o_result_bits;

    t_job        job_queue[$];
    logic [63:0] rsqrt_due[$];
    int          sent_count;
    int          checked_count;
    int          error_count;
    int          single_count;
    int          double_count;
    int          cycle_count;
    int          hold_left;
    bit          hold_done;
    bit          launch;
    bit          calm;

    fast_inverse_square_root i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_action       (i_action),
        .i_operand_bits (i_operand_bits),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_result_bits  (o_result_bits)
    );

    initial i_clk = 1'b0;
    always #2 i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // Software float model: value = sig * 2^exp, rounding to nearest even.
    // ------------------------------------------------------------------------
    function automatic int prec(input logic dbl);
        return dbl ? 53 : 24;
    endfunction

    function automatic int bias_of(input logic dbl);
        return dbl ? 1023 : 127;
    endfunction

    function automatic logic [63:0] special_bits(input logic dbl, input logic s,
                                                 input int cls);
        logic [63:0] r;
        if (cls == CL_NAN) begin
            r = dbl ? fisr_pkg::QNAN_D : {32'b0, fisr_pkg::QNAN_S};
        end else if (cls == CL_INF) begin
            r = dbl ? {s, 11'h7ff, 52'b0} : {32'b0, s, 8'hff, 23'b0};
        end else begin
            r = dbl ? {s, 63'b0} : {32'b0, s, 31'b0};
        end
        return r;
    endfunction

    // Split a pattern into sign, scaled exponent, integer significand, class.
    function automatic int split_fp(input logic dbl, input logic [63:0] v,
                                    output logic s, output int e,
                                    output logic [127:0] sig);
        int          ef;
        logic [51:0] fr;
        int          emax;
        if (dbl) begin
            s  = v[63];
            ef = int'(v[62:52]);
            fr = v[51:0];
        end else begin
            s  = v[31];
            ef = int'(v[30:23]);
            fr = {29'b0, v[22:0]};
        end
        emax = dbl ? 2047 : 255;
        sig  = 128'(fr);
        if (ef == emax) begin
            return (fr == 52'd0) ? CL_INF : CL_NAN;
        end
        if (ef == 0) begin
            e = 2 - bias_of(dbl) - prec(dbl);
            return (fr == 52'd0) ? CL_ZERO : CL_FINITE;
        end
        sig[prec(dbl) - 1] = 1'b1;
        e = ef - bias_of(dbl) - (prec(dbl) - 1);
        return CL_FINITE;
    endfunction

    // Round a nonzero exact value into the format.
    function automatic logic [63:0] round_fp(input logic dbl, input logic s,
                                             input int e, input logic [127:0] sig);
        int           p;
        int           msb;
        int           lsb_e;
        int           sh;
        int           ef;
        logic [127:0] m;
        logic [127:0] rem;
        logic [127:0] half;
        p   = prec(dbl);
        msb = 0;
        for (int i = 0; i < 128; i++) begin
            if (sig[i]) msb = i;
        end
        lsb_e = e + msb - (p - 1);
        if (lsb_e < 2 - bias_of(dbl) - p) lsb_e = 2 - bias_of(dbl) - p;
        sh = lsb_e - e;
        if (sh <= 0) begin
            m = sig << (-sh);
        end else if (sh > 120) begin
            m = '0;
        end else begin
            m    = sig >> sh;
            rem  = sig & ((128'd1 << sh) - 128'd1);
            half = 128'd1 << (sh - 1);
            if (rem > half || (rem == half && m[0])) m = m + 128'd1;
        end
        if (m[p]) begin
            m     = m >> 1;
            lsb_e = lsb_e + 1;
        end
        ef = m[p - 1] ? lsb_e + p - 1 + bias_of(dbl) : 0;
        if (ef >= (dbl ? 2047 : 255)) return special_bits(dbl, s, CL_INF);
        return dbl ? {s, ef[10:0], m[51:0]} : {32'b0, s, ef[7:0], m[22:0]};
    endfunction

    function automatic logic [63:0] fp_mul(input logic dbl, input logic [63:0] a,
                                           input logic [63:0] b);
        logic         sa, sb;
        int           ea, eb, ca, cb;
        logic [127:0] ma, mb;
        ca = split_fp(dbl, a, sa, ea, ma);
        cb = split_fp(dbl, b, sb, eb, mb);
        if (ca == CL_NAN || cb == CL_NAN) return special_bits(dbl, 1'b0, CL_NAN);
        if ((ca == CL_INF && cb == CL_ZERO) || (ca == CL_ZERO && cb == CL_INF))
            return special_bits(dbl, 1'b0, CL_NAN);
        if (ca == CL_INF || cb == CL_INF) return special_bits(dbl, sa ^ sb, CL_INF);
        if (ca == CL_ZERO || cb == CL_ZERO) return special_bits(dbl, sa ^ sb, CL_ZERO);
        return round_fp(dbl, sa ^ sb, ea + eb, ma * mb);
    endfunction

    function automatic logic [63:0] fp_sub(input logic dbl, input logic [63:0] a,
                                           input logic [63:0] b);
        logic         sa, sb, st;
        int           ea, eb, ca, cb, ct, d;
        logic [127:0] ma, mb, mt;
        ca = split_fp(dbl, a, sa, ea, ma);
        cb = split_fp(dbl, b, sb, eb, mb);
        sb = ~sb;
        if (ca == CL_NAN || cb == CL_NAN) return special_bits(dbl, 1'b0, CL_NAN);
        if (ca == CL_INF && cb == CL_INF && sa != sb) return special_bits(dbl, 1'b0, CL_NAN);
        if (ca == CL_INF) return special_bits(dbl, sa, CL_INF);
        if (cb == CL_INF) return special_bits(dbl, sb, CL_INF);
        if (ca == CL_ZERO && cb == CL_ZERO) return special_bits(dbl, sa & sb, CL_ZERO);
        if (cb == CL_ZERO) return a;
        if (ca == CL_ZERO) return dbl ? {sb, b[62:0]} : {32'b0, sb, b[30:0]};
        // put the larger exponent first
        if (eb > ea) begin
            st = sa; sa = sb; sb = st;
            ct = ea; ea = eb; eb = ct;
            mt = ma; ma = mb; mb = mt;
        end
        d  = ea - eb;
        ma = ma << 60;
        if (d > 100) begin
            mb = 128'd1;
        end else begin
            mt = (mb << 60) >> d;
            if ((mt << d) != (mb << 60)) mt[0] = 1'b1;
            mb = mt;
        end
        if (sa == sb) return round_fp(dbl, sa, ea - 60, ma + mb);
        if (ma == mb) return special_bits(dbl, 1'b0, CL_ZERO);
        if (ma > mb) return round_fp(dbl, sa, ea - 60, ma - mb);
        return round_fp(dbl, sb, ea - 60, mb - ma);
    endfunction

    function automatic logic [63:0] newton_step(input logic dbl, input logic [63:0] y,
                                                input logic [63:0] h);
        logic [63:0] t;
        logic [63:0] three_half;
        three_half = dbl ? fisr_pkg::THREE_HALF_D : {32'b0, fisr_pkg::THREE_HALF_S};
        t = fp_mul(dbl, h, y);
        t = fp_mul(dbl, t, y);
        t = fp_sub(dbl, three_half, t);
        return fp_mul(dbl, y, t);
    endfunction

    function automatic logic [63:0] rsqrt_expected(input logic dbl, input logic [63:0] x);
        logic [63:0] h;
        logic [63:0] y;
        logic [31:0] xs;
        logic [31:0] shs;
        if (dbl) begin
            h = fp_mul(1'b1, x, fisr_pkg::HALF_D);
            y = fisr_pkg::MAGIC_D - (x >> 1);
            y = newton_step(1'b1, y, h);
            y = newton_step(1'b1, y, h);
            if (&y[62:52] && y[51:0] != 52'd0) y = fisr_pkg::QNAN_D;
        end else begin
            xs  = x[31:0];
            h   = fp_mul(1'b0, {32'b0, fisr_pkg::HALF_S}, {32'b0, xs});
            shs = (xs >> 1) | (xs & 32'h80000000);
            y   = {32'b0, fisr_pkg::MAGIC_S - shs};
            y   = newton_step(1'b0, y, h);
            if (&y[30:23] && y[22:0] != 23'd0) y = {32'b0, fisr_pkg::QNAN_S};
        end
        return y;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus construction
    // ------------------------------------------------------------------------
    function automatic logic [63:0] random_operand(input logic dbl);
        logic [63:0] v;
        logic        s;
        int          kind;
        v    = {$urandom, $urandom};
        s    = ($urandom_range(0, 9) == 0);
        kind = $urandom_range(0, 9);
        if (dbl) begin
            case (kind)
                0, 1, 2, 3: v[62:52] = 11'($urandom_range(900, 1150));
                4:          v[62:52] = 11'($urandom_range(1, 2046));
                5:          v[62:52] = 11'd0;
                6:          v[62:52] = 11'($urandom_range(2040, 2047));
                7:          v[62:52] = 11'($urandom_range(0, 8));
                default: ;
            endcase
            if (kind != 8) v[63] = s;
            if (kind == 9) v[51:0] = ($urandom_range(0, 1) != 0) ? '0 : 52'd1;
        end else begin
            case (kind)
                0, 1, 2, 3: v[30:23] = 8'($urandom_range(90, 160));
                4:          v[30:23] = 8'($urandom_range(1, 254));
                5:          v[30:23] = 8'd0;
                6:          v[30:23] = 8'($urandom_range(250, 255));
                7:          v[30:23] = 8'($urandom_range(0, 8));
                default: ;
            endcase
            if (kind != 8) v[31] = s;
            if (kind == 9) v[22:0] = ($urandom_range(0, 1) != 0) ? '0 : 23'd1;
        end
        return v;
    endfunction

    task automatic add_job(input logic dbl, input logic [63:0] v);
        t_job j;
        j.drain   = 1'b0;
        j.action  = dbl;
        j.operand = v;
        job_queue.push_back(j);
    endtask

    task automatic add_drain();
        t_job j;
        j.drain   = 1'b1;
        j.action  = 1'b0;
        j.operand = '0;
        job_queue.push_back(j);
    endtask

    // ------------------------------------------------------------------------
    // Driver: offer queued items; hold valid and payload until the transfer.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid        <= 1'b0;
            i_action       <= 1'b0;
            i_operand_bits <= '0;
        end else begin
            launch = !i_valid;
            if (i_valid && o_ready) begin
                rsqrt_due.push_back(rsqrt_expected(i_action, i_operand_bits));
                sent_count = sent_count + 1;
                if (i_action) double_count++;
                else single_count++;
                launch = 1'b1;
            end
            if (launch) begin
                // drop a drain marker once the block has given everything back
                if (job_queue.size() > 0 && job_queue[0].drain && rsqrt_due.size() == 0)
                    void'(job_queue.pop_front());
                if (job_queue.size() > 0 && !job_queue[0].drain &&
                    (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
                    i_valid        <= 1'b1;
                    i_action       <= job_queue[0].action;
                    i_operand_bits <= job_queue[0].operand;
                    void'(job_queue.pop_front());
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: check each transfer out against the oldest prediction and pace
    // i_ready, including one long hold-off that backs the pipeline up.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                if (rsqrt_due.size() == 0) begin
                    error_count++;
                    $display("%0t: unexpected result, expected none, actual %h",
                             $time, o_result_bits);
                end else begin
                    if (o_result_bits !== rsqrt_due[0]) begin
                        error_count++;
                        $display("%0t: result_bits mismatch, expected %h, actual %h",
                                 $time, rsqrt_due[0], o_result_bits);
                    end
                    void'(rsqrt_due.pop_front());
                    checked_count++;
                end
            end
            if (hold_left > 0) begin
                hold_left = hold_left - 1;
                i_ready <= 1'b0;
            end else if (!hold_done && sent_count >= 400) begin
                hold_done = 1'b1;
                hold_left = 300;
                i_ready <= 1'b0;
            end else begin
                i_ready <= calm || $urandom_range(0, 99) >= IDLE_PCT;
            end
        end
    end

    // Idle-free stretch in the middle of the random part
    always_comb calm = (sent_count >= 600) && (sent_count < 800);

    // Cycle counter; end the run if the block wedges
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: timeout, %0d predictions still outstanding",
                     $time, rsqrt_due.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------------
    initial begin
        sent_count    = 0;
        checked_count = 0;
        error_count   = 0;
        single_count  = 0;
        double_count  = 0;
        cycle_count   = 0;
        hold_left     = 0;
        hold_done     = 1'b0;
        i_rst_n       = 1'b0;

        // Directed single: signed zeros, infinities, NaNs, subnormals, limits.
        // Upper bits carry junk, which the block must ignore.
        add_job(1'b0, 64'h00000000_00000000);
        add_job(1'b0, 64'hffffffff_80000000);
        add_job(1'b0, 64'h12345678_7f800000);
        add_job(1'b0, 64'h00000000_ff800000);
        add_job(1'b0, 64'h00000000_7fc00001);
        add_job(1'b0, 64'h00000000_ff800001);
        add_job(1'b0, 64'hdeadbeef_3f800000);
        add_job(1'b0, 64'h00000000_40800000);
        add_job(1'b0, 64'h00000000_bf800000);
        add_job(1'b0, 64'h00000000_00000001);
        add_job(1'b0, 64'h00000000_007fffff);
        add_job(1'b0, 64'h00000000_00800000);
        add_job(1'b0, 64'h00000000_7f7fffff);
        // Directed double
        add_job(1'b1, 64'h00000000_00000000);
        add_job(1'b1, 64'h80000000_00000000);
        add_job(1'b1, 64'h7ff00000_00000000);
        add_job(1'b1, 64'hfff00000_00000000);
        add_job(1'b1, 64'h7ff80000_00000001);
        add_job(1'b1, 64'h7ff00000_00000001);
        add_job(1'b1, 64'h3ff00000_00000000);
        add_job(1'b1, 64'hbff00000_00000000);
        add_job(1'b1, 64'h00000000_00000001);
        add_job(1'b1, 64'h000fffff_ffffffff);
        add_job(1'b1, 64'h00100000_00000000);
        add_job(1'b1, 64'h7fefffff_ffffffff);
        add_drain();

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == 900) add_drain();
            add_job(1'($urandom_range(0, 1)), random_operand(1'($urandom_range(0, 1))));
        end

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (job_queue.size() > 0 || i_valid || rsqrt_due.size() > 0)
            @(posedge i_clk);
        // let any stray result surface
        repeat (80) @(posedge i_clk);

        $display("Checked %0d results: %0d single and %0d double operands, with a long",
                 checked_count, single_count, double_count);
        $display("output hold-off, two drain pauses and random idling on both sides.");
        if (error_count == 0 && rsqrt_due.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
